FILE: rtl/core/sspt_pkg.sv
// ----------------------------------------------------------------------------
// sspt_pkg
// shared types and codes of the session slot pairing table
// ----------------------------------------------------------------------------
`default_nettype none

package sspt_pkg;

    localparam int SLOT_W    = 8;
    localparam int WORD_LOG  = 5;
    localparam int WORD_BITS = 1 << WORD_LOG;

    typedef logic [1:0]        op_t;
    typedef logic [2:0]        status_t;
    typedef logic [SLOT_W-1:0] slot_t;

    localparam op_t OP_ALLOC  = 2'd0;
    localparam op_t OP_CLOSE  = 2'd1;
    localparam op_t OP_PAIR   = 2'd2;
    localparam op_t OP_LOOKUP = 2'd3;

    localparam status_t ST_OK           = 3'd0;
    localparam status_t ST_NONE_FREE    = 3'd1;
    localparam status_t ST_BAD_SLOT     = 3'd2;
    localparam status_t ST_SELF         = 3'd3;
    localparam status_t ST_REQ_PAIRED   = 3'd4;
    localparam status_t ST_TGT_INACTIVE = 3'd5;
    localparam status_t ST_TGT_PAIRED   = 3'd6;
    localparam status_t ST_UNPAIRED     = 3'd7;

endpackage

`default_nettype wire

FILE: rtl/core/session_slot_pairing_table.sv
// ----------------------------------------------------------------------------
// session_slot_pairing_table
// Keeps which session slots (1 to SLOTS) are active and which slot each one
// is paired with. A command word is taken when start is high and busy is low.
// Allocate, lookup, closing an unpaired slot and every refused command finish
// in S_ALLOC or S_EXEC; closing a paired slot and a successful pairing also
// pass S_CLOSE2 or S_PAIR2, as the partner memory has one write port and both
// entries of the pair are written. The result word appears for one cycle with
// done, in the cycle busy drops, so the next start can be taken in that same
// cycle; the result cannot be held off and must be captured then. After reset
// the block clears both memories with busy high, one partner entry per cycle.
// The lowest free slot comes from 32-bit bitmap words with a full flag each.
// ----------------------------------------------------------------------------
`default_nettype none

module session_slot_pairing_table #(
    parameter int SLOTS = 128
) (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   start,
    output logic                  busy,
    input  wire sspt_pkg::op_t    op,
    input  wire sspt_pkg::slot_t  slot,
    input  wire sspt_pkg::slot_t  target_slot,
    output logic                  done,
    output sspt_pkg::status_t     status,
    output sspt_pkg::slot_t       granted_slot,
    output sspt_pkg::slot_t       partner_slot
);

    localparam int IW  = $clog2(SLOTS);
    localparam int WW  = sspt_pkg::WORD_BITS;
    localparam int WB  = sspt_pkg::WORD_LOG;
    localparam int NW  = (SLOTS + WW - 1) / WW;
    localparam int NWI = (NW > 1) ? $clog2(NW) : 1;
    localparam int XW  = (IW > sspt_pkg::SLOT_W) ? IW : sspt_pkg::SLOT_W;
    localparam logic [15:0] SLOTS_W = 16'(SLOTS);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_ALLOC  = 3'd2;
    localparam logic [2:0] S_EXEC   = 3'd3;
    localparam logic [2:0] S_CLOSE2 = 3'd4;
    localparam logic [2:0] S_PAIR2  = 3'd5;

    function automatic logic [IW-1:0] slot_idx(input sspt_pkg::slot_t s);
        logic [XW-1:0] e;
        e = XW'(s) - XW'(1);
        return IW'(e);
    endfunction

    function automatic logic in_range(input sspt_pkg::slot_t s);
        return (s != '0) && (16'(s) <= SLOTS_W);
    endfunction

    function automatic logic [NWI-1:0] word_of(input logic [IW-1:0] idx);
        return NWI'(idx >> WB);
    endfunction

    function automatic logic [WB-1:0] bit_of(input logic [IW-1:0] idx);
        return WB'(idx);
    endfunction

    // slots past the top are marked taken so they are never granted
    function automatic logic [WW-1:0] init_word(input logic [NWI-1:0] w);
        logic [WW-1:0] r;
        for (int b = 0; b < WW; b++)
        begin
            r[b] = ((int'(w) * WW + b) >= SLOTS);
        end
        return r;
    endfunction

    // memories
    logic [sspt_pkg::SLOT_W-1:0] pmem [SLOTS];
    logic [WW-1:0]               bmem [NW];

    logic [2:0]            state_reg, state_next;
    sspt_pkg::op_t         op_reg;
    sspt_pkg::slot_t       me_reg, tgt_reg;
    logic                  none_free_reg;
    logic [NWI-1:0]        aw_reg;
    logic [IW-1:0]         pidx_reg, pidx_next;
    logic [IW-1:0]         clr_reg, clr_next;
    logic [NW-1:0]         full_reg, full_next;
    logic                  done_reg, done_next;
    sspt_pkg::status_t     status_reg, status_next;
    sspt_pkg::slot_t       granted_reg, granted_next;
    sspt_pkg::slot_t       partner_reg, partner_next;

    sspt_pkg::slot_t       pa_q, pb_q;
    logic [WW-1:0]         ba_q, bb_q;

    logic                  pm_we;
    logic [IW-1:0]         pm_waddr;
    sspt_pkg::slot_t       pm_wdata;
    logic                  bm_we;
    logic [NWI-1:0]        bm_waddr;
    logic [WW-1:0]         bm_wdata;

    logic [IW-1:0]         in_me_idx, in_tgt_idx;
    logic [NWI-1:0]        bm_raddr_a;
    logic [NWI-1:0]        ffw;
    logic                  any_free;
    logic [WB-1:0]         fb;
    logic [WW-1:0]         alloc_word;
    logic [IW-1:0]         alloc_idx;
    logic [IW:0]           alloc_num;
    logic [IW-1:0]         me_idx, tgt_idx;
    logic                  me_ok, tgt_act;
    logic                  accept;

    assign accept     = start && (state_reg == S_IDLE);
    assign in_me_idx  = slot_idx(slot);
    assign in_tgt_idx = slot_idx(target_slot);
    assign bm_raddr_a = (op == sspt_pkg::OP_ALLOC) ? ffw : word_of(in_me_idx);

    assign me_idx  = slot_idx(me_reg);
    assign tgt_idx = slot_idx(tgt_reg);
    assign me_ok   = in_range(me_reg) && ba_q[bit_of(me_idx)];
    assign tgt_act = in_range(tgt_reg) && bb_q[bit_of(tgt_idx)];

    // lowest word with a free slot
    always_comb
    begin
        ffw      = '0;
        any_free = 1'b0;
        for (int i = NW - 1; i >= 0; i--)
        begin
            if (!full_reg[i])
            begin
                ffw      = NWI'(i);
                any_free = 1'b1;
            end
        end
    end

    // lowest free slot in that word
    always_comb
    begin
        fb = '0;
        for (int i = WW - 1; i >= 0; i--)
        begin
            if (!ba_q[i])
            begin
                fb = WB'(i);
            end
        end
    end

    assign alloc_word = ba_q | (WW'(1) << fb);
    assign alloc_idx  = IW'({aw_reg, fb});
    assign alloc_num  = {1'b0, alloc_idx} + (IW + 1)'(1);

    always_ff @(posedge clk)
    begin
        if (pm_we)
        begin
            pmem[pm_waddr] <= pm_wdata;
        end
        pa_q <= pmem[in_me_idx];
        pb_q <= pmem[in_tgt_idx];
    end

    always_ff @(posedge clk)
    begin
        if (bm_we)
        begin
            bmem[bm_waddr] <= bm_wdata;
        end
        ba_q <= bmem[bm_raddr_a];
        bb_q <= bmem[word_of(in_tgt_idx)];
    end

    always_comb
    begin
        state_next   = state_reg;
        pidx_next    = pidx_reg;
        clr_next     = clr_reg;
        full_next    = full_reg;
        done_next    = 1'b0;
        status_next  = sspt_pkg::ST_OK;
        granted_next = '0;
        partner_next = '0;
        pm_we        = 1'b0;
        pm_waddr     = me_idx;
        pm_wdata     = '0;
        bm_we        = 1'b0;
        bm_waddr     = aw_reg;
        bm_wdata     = ba_q;

        case (state_reg)
            S_CLEAR:
            begin
                pm_we    = 1'b1;
                pm_waddr = clr_reg;
                if (clr_reg < IW'(NW))
                begin
                    bm_we    = 1'b1;
                    bm_waddr = NWI'(clr_reg);
                    bm_wdata = init_word(NWI'(clr_reg));
                end
                clr_next = clr_reg + IW'(1);
                if (clr_reg == IW'(SLOTS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = (op == sspt_pkg::OP_ALLOC) ? S_ALLOC : S_EXEC;
                end
            end
            S_ALLOC:
            begin
                done_next  = 1'b1;
                state_next = S_IDLE;
                if (none_free_reg)
                begin
                    status_next = sspt_pkg::ST_NONE_FREE;
                end
                else
                begin
                    bm_we             = 1'b1;
                    bm_waddr          = aw_reg;
                    bm_wdata          = alloc_word;
                    full_next[aw_reg] = &alloc_word;
                    pm_we             = 1'b1;
                    pm_waddr          = alloc_idx;
                    granted_next      = sspt_pkg::SLOT_W'(alloc_num);
                end
            end
            S_EXEC:
            begin
                done_next  = 1'b1;
                state_next = S_IDLE;
                if (!me_ok)
                begin
                    status_next = sspt_pkg::ST_BAD_SLOT;
                end
                else
                begin
                    case (op_reg)
                        sspt_pkg::OP_CLOSE:
                        begin
                            pm_we                      = 1'b1;
                            pm_waddr                   = me_idx;
                            bm_we                      = 1'b1;
                            bm_waddr                   = word_of(me_idx);
                            bm_wdata                   = ba_q & ~(WW'(1) << bit_of(me_idx));
                            full_next[word_of(me_idx)] = 1'b0;
                            if (in_range(pa_q))
                            begin
                                pidx_next  = slot_idx(pa_q);
                                done_next  = 1'b0;
                                state_next = S_CLOSE2;
                            end
                        end
                        sspt_pkg::OP_PAIR:
                        begin
                            if (tgt_reg == me_reg)
                            begin
                                status_next = sspt_pkg::ST_SELF;
                            end
                            else if (pa_q != '0)
                            begin
                                status_next = sspt_pkg::ST_REQ_PAIRED;
                            end
                            else if (!tgt_act)
                            begin
                                status_next = sspt_pkg::ST_TGT_INACTIVE;
                            end
                            else if (pb_q != '0)
                            begin
                                status_next = sspt_pkg::ST_TGT_PAIRED;
                            end
                            else
                            begin
                                pm_we      = 1'b1;
                                pm_waddr   = me_idx;
                                pm_wdata   = tgt_reg;
                                done_next  = 1'b0;
                                state_next = S_PAIR2;
                            end
                        end
                        sspt_pkg::OP_LOOKUP:
                        begin
                            if (pa_q == '0)
                            begin
                                status_next = sspt_pkg::ST_UNPAIRED;
                            end
                            else
                            begin
                                partner_next = pa_q;
                            end
                        end
                        default:
                        begin
                            status_next = sspt_pkg::ST_OK;
                        end
                    endcase
                end
            end
            S_CLOSE2:
            begin
                pm_we      = 1'b1;
                pm_waddr   = pidx_reg;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            S_PAIR2:
            begin
                pm_we        = 1'b1;
                pm_waddr     = tgt_idx;
                pm_wdata     = me_reg;
                partner_next = tgt_reg;
                done_next    = 1'b1;
                state_next   = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            full_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            full_reg  <= full_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg        <= op;
            me_reg        <= slot;
            tgt_reg       <= target_slot;
            none_free_reg <= !any_free;
            aw_reg        <= ffw;
        end
        pidx_reg    <= pidx_next;
        status_reg  <= status_next;
        granted_reg <= granted_next;
        partner_reg <= partner_next;
    end

    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign status       = status_reg;
    assign granted_slot = granted_reg;
    assign partner_slot = partner_reg;

endmodule

`default_nettype wire

FILE: rtl/core/sspt_checker.sv
// ----------------------------------------------------------------------------
// sspt_checker
// port-level checks of the session slot pairing table
// ----------------------------------------------------------------------------
`default_nettype none

module sspt_checker (
    input wire                    clk,
    input wire                    rst_n,
    input wire                    start,
    input wire                    busy,
    input wire sspt_pkg::op_t     op,
    input wire sspt_pkg::slot_t   slot,
    input wire sspt_pkg::slot_t   target_slot,
    input wire                    done,
    input wire sspt_pkg::status_t status,
    input wire sspt_pkg::slot_t   granted_slot,
    input wire sspt_pkg::slot_t   partner_slot
);

    // an accepted word keeps the block busy in the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("no busy after accepted word");

    // a result word only follows a busy cycle and ends it
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy && $past(busy))
        else $error("result word outside an operation");

    // a grant is only reported with ok status and no partner
    a_grant_ok: assert property (@(posedge clk) disable iff (!rst_n)
        done && granted_slot != '0 |-> status == sspt_pkg::ST_OK && partner_slot == '0)
        else $error("grant with bad status or partner");

    // refused words carry no slot numbers
    a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && status != sspt_pkg::ST_OK |-> granted_slot == '0 && partner_slot == '0)
        else $error("refused word carries slot numbers");

endmodule

bind session_slot_pairing_table sspt_checker u_sspt_checker (.*);

`default_nettype wire

FILE: tb/sv/session_slot_pairing_table_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// session_slot_pairing_table_checker
// Watches the command and result channels of the pairing table. Every command
// word taken is run through a local copy of the slot map and partner table,
// and the answer it should give is queued. Each result word is compared field
// by field with the oldest queued answer.
// ----------------------------------------------------------------------------

module session_slot_pairing_table_checker #(
    parameter int SLOTS = 128
) (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   start,
    input  wire                   busy,
    input  wire sspt_pkg::op_t    op,
    input  wire sspt_pkg::slot_t  slot,
    input  wire sspt_pkg::slot_t  target_slot,
    input  wire                   done,
    input  wire sspt_pkg::status_t status,
    input  wire sspt_pkg::slot_t  granted_slot,
    input  wire sspt_pkg::slot_t  partner_slot,
    output int                    mismatches,
    output int                    answers_pending
);

    import sspt_pkg::*;

    typedef struct packed {
        status_t status;
        slot_t   granted;
        slot_t   partner;
    } answer_t;

    bit      live [1:SLOTS];
    slot_t   mates [1:SLOTS];
    answer_t answers_due [$];
    answer_t want;
    int      field_errs;

    function automatic bit is_live(slot_t s);
        if (s < 1 || s > SLOTS)
            return 1'b0;
        return live[s];
    endfunction

    function automatic answer_t serve_request(op_t o, slot_t s, slot_t t);
        answer_t a;
        slot_t   mate;
        a = '0;
        if (o == OP_ALLOC)
        begin
            a.status = ST_NONE_FREE;
            for (int i = 1; i <= SLOTS; i++)
            begin
                if (!live[i])
                begin
                    live[i]   = 1'b1;
                    mates[i]  = '0;
                    a.status  = ST_OK;
                    a.granted = slot_t'(i);
                    break;
                end
            end
        end
        else if (!is_live(s))
        begin
            a.status = ST_BAD_SLOT;
        end
        else if (o == OP_CLOSE)
        begin
            mate = mates[s];
            if (mate >= 1 && mate <= SLOTS)
                mates[mate] = '0;
            mates[s] = '0;
            live[s]  = 1'b0;
        end
        else if (o == OP_PAIR)
        begin
            if (t == s)
                a.status = ST_SELF;
            else if (mates[s] != '0)
                a.status = ST_REQ_PAIRED;
            else if (!is_live(t))
                a.status = ST_TGT_INACTIVE;
            else if (mates[t] != '0)
                a.status = ST_TGT_PAIRED;
            else
            begin
                mates[s]  = t;
                mates[t]  = s;
                a.partner = t;
            end
        end
        else
        begin
            if (mates[s] == '0)
                a.status = ST_UNPAIRED;
            else
                a.partner = mates[s];
        end
        return a;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 1; i <= SLOTS; i++)
            begin
                live[i]  = 1'b0;
                mates[i] = '0;
            end
            answers_due.delete();
            mismatches      <= 0;
            answers_pending <= 0;
        end
        else
        begin
            if (done)
            begin
                if (answers_due.size() == 0)
                begin
                    $error("result word with none expected: status %0d granted %0d partner %0d",
                           status, granted_slot, partner_slot);
                    field_errs = 1;
                end
                else
                begin
                    want       = answers_due.pop_front();
                    field_errs = 0;
                    if (status !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d", want.status, status);
                        field_errs++;
                    end
                    if (granted_slot !== want.granted)
                    begin
                        $error("granted_slot: expected %0d, actual %0d",
                               want.granted, granted_slot);
                        field_errs++;
                    end
                    if (partner_slot !== want.partner)
                    begin
                        $error("partner_slot: expected %0d, actual %0d",
                               want.partner, partner_slot);
                        field_errs++;
                    end
                end
                mismatches <= mismatches + field_errs;
            end
            if (start && !busy)
                answers_due = {answers_due, serve_request(op, slot, target_slot)};
            answers_pending <= answers_due.size();
        end
    end

endmodule

FILE: tb/sv/session_slot_pairing_table_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// session_slot_pairing_table_tb
// Drives command words into the pairing table: a short directed run over the
// refusal codes, then random traffic in three idling phases, with one pass
// that fills every slot, works the top slot and closes them all again. The
// checker beside the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------

module session_slot_pairing_table_tb;

    import sspt_pkg::*;

    localparam int SLOT_COUNT = 128;

    logic    clk         = 1'b0;
    logic    rst_n       = 1'b0;
    logic    start       = 1'b0;
    op_t     op          = OP_ALLOC;
    slot_t   slot        = '0;
    slot_t   target_slot = '0;
    logic    busy;
    logic    done;
    status_t status;
    slot_t   granted_slot;
    slot_t   partner_slot;
    int      mismatches;
    int      answers_pending;
    int      idle_pct;

    always #5 clk = ~clk;

    session_slot_pairing_table #(
        .SLOTS(SLOT_COUNT)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .op           (op),
        .slot         (slot),
        .target_slot  (target_slot),
        .done         (done),
        .status       (status),
        .granted_slot (granted_slot),
        .partner_slot (partner_slot)
    );

    session_slot_pairing_table_checker #(
        .SLOTS(SLOT_COUNT)
    ) u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .op              (op),
        .slot            (slot),
        .target_slot     (target_slot),
        .done            (done),
        .status          (status),
        .granted_slot    (granted_slot),
        .partner_slot    (partner_slot),
        .mismatches      (mismatches),
        .answers_pending (answers_pending)
    );

    task automatic send_word(op_t o, slot_t s, slot_t t);
        start       <= 1'b1;
        op          <= o;
        slot        <= s;
        target_slot <= t;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        @(posedge clk);
        while (answers_pending != 0)
            @(posedge clk);
    endtask

    // mostly low slots, where allocate keeps the active ones
    function automatic slot_t pick_slot();
        int r;
        r = $urandom_range(99);
        if (r < 80)
            return slot_t'($urandom_range(16, 1));
        else if (r < 90)
            return slot_t'($urandom_range(SLOT_COUNT, 1));
        else if (r < 95)
            return '0;
        return slot_t'($urandom_range(255, SLOT_COUNT + 1));
    endfunction

    task automatic run_random(int count);
        int    r;
        slot_t s;
        slot_t t;
        repeat (count)
        begin
            r = $urandom_range(99);
            s = pick_slot();
            t = ($urandom_range(9) == 0) ? s : pick_slot();
            if (r < 20)
                send_word(OP_ALLOC, s, t);
            else if (r < 45)
                send_word(OP_CLOSE, s, t);
            else if (r < 75)
                send_word(OP_PAIR, s, t);
            else
                send_word(OP_LOOKUP, s, t);
        end
    endtask

    initial
    begin
        #5ms;
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        idle_pct = 20;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed words on an empty table
        send_word(OP_LOOKUP, 8'd0, 8'd0);
        send_word(OP_CLOSE, 8'd5, 8'd0);
        send_word(OP_PAIR, 8'd255, 8'd1);
        send_word(OP_ALLOC, 8'd0, 8'd0);
        send_word(OP_ALLOC, 8'd255, 8'd255);
        send_word(OP_ALLOC, 8'd0, 8'd0);
        send_word(OP_LOOKUP, 8'd1, 8'd0);
        send_word(OP_PAIR, 8'd1, 8'd1);
        send_word(OP_PAIR, 8'd1, 8'd0);
        send_word(OP_PAIR, 8'd1, 8'd200);
        send_word(OP_PAIR, 8'd1, 8'd9);
        send_word(OP_PAIR, 8'd1, 8'd2);
        send_word(OP_PAIR, 8'd1, 8'd3);
        send_word(OP_PAIR, 8'd3, 8'd2);
        send_word(OP_LOOKUP, 8'd2, 8'd0);
        send_word(OP_CLOSE, 8'd1, 8'd0);
        send_word(OP_LOOKUP, 8'd2, 8'd0);
        send_word(OP_ALLOC, 8'd0, 8'd0);
        send_word(OP_LOOKUP, 8'd1, 8'd0);
        send_word(OP_PAIR, 8'd2, 8'd3);
        send_word(OP_CLOSE, 8'd3, 8'd0);
        send_word(OP_CLOSE, 8'd3, 8'd0);
        send_word(OP_LOOKUP, 8'd128, 8'd0);
        wait_drained();

        idle_pct = 20;
        run_random(270);
        wait_drained();

        idle_pct = 82;
        run_random(270);
        wait_drained();

        idle_pct = 0;
        run_random(135);

        // fill every slot, work the top one, then close them all
        repeat (SLOT_COUNT + 2)
            send_word(OP_ALLOC, pick_slot(), pick_slot());
        send_word(OP_CLOSE, slot_t'(SLOT_COUNT), 8'd0);
        send_word(OP_ALLOC, 8'd0, 8'd0);
        send_word(OP_PAIR, slot_t'(SLOT_COUNT - 1), slot_t'(SLOT_COUNT));
        send_word(OP_LOOKUP, slot_t'(SLOT_COUNT), 8'd0);
        send_word(OP_PAIR, slot_t'(SLOT_COUNT), 8'd1);
        send_word(OP_PAIR, 8'd1, slot_t'(SLOT_COUNT));
        send_word(OP_CLOSE, slot_t'(SLOT_COUNT), 8'd0);
        send_word(OP_LOOKUP, slot_t'(SLOT_COUNT - 1), 8'd0);
        for (int i = 1; i <= SLOT_COUNT; i++)
            send_word(OP_CLOSE, slot_t'(i), pick_slot());

        run_random(135);

        wait_drained();
        repeat (8) @(posedge clk);
        if (mismatches == 0 && answers_pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
